FILE: design/difference_sharpening_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// difference sharpening filter assertion macros
// shared concurrent assertion forms for the filter checker
// ----------------------------------------------------------------------------
`ifndef DIFFERENCE_SHARPENING_FILTER_UNIT_MACROS_SVH
`define DIFFERENCE_SHARPENING_FILTER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define DSF_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define DSF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/dsf_pkg.sv
// ----------------------------------------------------------------------------
// dsf_pkg
// types and fixed constants of the difference sharpening filter
// ----------------------------------------------------------------------------
package dsf_pkg;

	localparam int DATA_W    = 32;
	localparam int GAIN_W    = 16;
	localparam int FMT_W     = 3;
	localparam int CNT_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CNT_CMP_W = 8;

	typedef enum logic [FMT_W-1:0] {
		FMT_S8  = 3'd0,
		FMT_U8  = 3'd1,
		FMT_S16 = 3'd2,
		FMT_U16 = 3'd3,
		FMT_S32 = 3'd4,
		FMT_U32 = 3'd5
	} fmt_e_t;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FORMAT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd2;

	localparam logic [GAIN_W-1:0] GAIN_RESET     = 16'd0;
	localparam logic [FMT_W-1:0]  FORMAT_RESET   = 3'd2;
	localparam logic [CNT_W-1:0]  CHANNELS_RESET = 4'd2;

endpackage

FILE: design/dsf_ram.sv
// ----------------------------------------------------------------------------
// dsf_ram
// generic single-write, single-read ram with registered read (read-first)
// ----------------------------------------------------------------------------
module dsf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

endmodule

FILE: design/difference_sharpening_filter_unit.sv
// ----------------------------------------------------------------------------
// difference_sharpening_filter_unit
// first difference emphasis on interleaved audio samples with saturation
// ----------------------------------------------------------------------------
//  channel  | role                           | payload
//  s_axis   | sample in                      | tdata sample_in, tuser buffer_start
//  m_axis   | sample out                     | tdata sample_out, tuser clipped
//  cfg      | register write, always ready   | cfg_index, cfg_data
//
//  one sample per cycle sustained while the output is not stalled
//  stages: history ram read, difference, gain multiply, scale and saturate
//  a stalled output holds its data; empty stages still fill behind it
//  reset loads config defaults, clears channel counter, sets seeding flag;
//  history is undefined until a channel is first written in a seeding frame
// ----------------------------------------------------------------------------
module difference_sharpening_filter_unit
	import dsf_pkg::*;
#(
	parameter int MAX_CHANNELS   = 8,
	parameter int SAMPLE_WIDTH   = 32,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [DATA_W-1:0]    s_axis_tdata,  // [31:0] sample_in
	input  logic                 s_axis_tuser,  // [0] buffer_start
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [DATA_W-1:0]    m_axis_tdata,  // [31:0] sample_out
	output logic                 m_axis_tuser,  // [0] clipped
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data
);

	localparam int AW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int VW  = SAMPLE_WIDTH + 1;
	localparam int DFW = VW + 1;
	localparam int PW  = DFW + GAIN_W;
	localparam int SW  = PW + 1;
	localparam logic [SW-1:0] ROUND_ADD = SW'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

	// config registers
	logic signed [GAIN_W-1:0] gain_q;
	logic [FMT_W-1:0]         sample_format_q;
	logic [CNT_W-1:0]         channel_count_q;

	// channel tracking
	logic [AW-1:0] channel_index_q;
	logic          seeding_frame_q;

	// format decode
	logic [5:0]              fmt_bits;
	logic [5:0]              width_w;
	logic                    fmt_sgn;
	logic [32:0]             mask_full;
	logic [SAMPLE_WIDTH-1:0] mask;
	logic [SAMPLE_WIDTH-1:0] sign_bit;
	logic [VW-1:0]           span;
	logic signed [SW-1:0]    hi_v;
	logic signed [SW-1:0]    lo_v;

	// handshake
	logic accept;
	logic out_en;
	logic en_s1;
	logic en_s2;
	logic en_s3;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic out_valid_q;

	// accept stage
	logic [SAMPLE_WIDTH-1:0] raw_in;
	logic                    seed_in;
	logic [AW-1:0]           ch_in;
	logic [AW:0]             ch_inc;
	logic [CNT_CMP_W-1:0]    cnt_eff;
	logic                    wrap;
	logic [SAMPLE_WIDTH-1:0] prev_rd;

	// pipeline payload
	logic [SAMPLE_WIDTH-1:0] raw_s1;
	logic                    seed_s1;
	logic [SAMPLE_WIDTH-1:0] raw_s2;
	logic                    seed_s2;
	logic signed [VW-1:0]    x_s2;
	logic signed [DFW-1:0]   diff_s2;
	logic [SAMPLE_WIDTH-1:0] raw_s3;
	logic                    seed_s3;
	logic signed [VW-1:0]    x_s3;
	logic signed [PW-1:0]    prod_s3;
	logic [DATA_W-1:0]       sample_out_q;
	logic                    clipped_q;

	// final stage
	logic signed [VW-1:0]    x_val;
	logic signed [VW-1:0]    p_val;
	logic signed [SW-1:0]    sum_full;
	logic signed [SW-1:0]    sum_adj;
	logic signed [SW-1:0]    res;
	logic signed [SW-1:0]    res_sat;
	logic                    clip_c;
	logic [SAMPLE_WIDTH-1:0] res_bits;

	function automatic logic signed [VW-1:0] to_val(
		input logic [SAMPLE_WIDTH-1:0] bits,
		input logic [SAMPLE_WIDTH-1:0] msk,
		input logic [SAMPLE_WIDTH-1:0] sbit,
		input logic [VW-1:0]           spn,
		input logic                    sgn
	);
		logic [SAMPLE_WIDTH-1:0] m;
		logic [VW-1:0]           v;
		m = bits & msk;
		v = {1'b0, m};
		if (sgn && ((m & sbit) != '0)) begin
			v = v - spn;
		end
		return signed'(v);
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q          <= signed'(GAIN_RESET);
			sample_format_q <= FORMAT_RESET;
			channel_count_q <= CHANNELS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GAIN:     gain_q          <= signed'(cfg_data);
				CFG_FORMAT:   sample_format_q <= cfg_data[FMT_W-1:0];
				CFG_CHANNELS: channel_count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (fmt_e_t'(sample_format_q))
			FMT_S8:  begin fmt_bits = 6'd8;  fmt_sgn = 1'b1; end
			FMT_U8:  begin fmt_bits = 6'd8;  fmt_sgn = 1'b0; end
			FMT_S16: begin fmt_bits = 6'd16; fmt_sgn = 1'b1; end
			FMT_U16: begin fmt_bits = 6'd16; fmt_sgn = 1'b0; end
			FMT_S32: begin fmt_bits = 6'd32; fmt_sgn = 1'b1; end
			default: begin fmt_bits = 6'd32; fmt_sgn = 1'b0; end
		endcase
		width_w   = (fmt_bits > 6'(SAMPLE_WIDTH)) ? 6'(SAMPLE_WIDTH) : fmt_bits;
		mask_full = (33'd1 << width_w) - 33'd1;
		mask      = mask_full[SAMPLE_WIDTH-1:0];
		sign_bit  = mask & ~(mask >> 1);
		span      = VW'(1) << width_w;
		hi_v      = fmt_sgn ? signed'(SW'(mask >> 1)) : signed'(SW'(mask));
		lo_v      = fmt_sgn ? ~hi_v : '0;
	end

	assign out_en        = !out_valid_q || m_axis_tready;
	assign en_s3         = !valid_s3 || out_en;
	assign en_s2         = !valid_s2 || en_s3;
	assign en_s1         = !valid_s1 || en_s2;
	assign s_axis_tready = en_s1;
	assign accept        = s_axis_tvalid && en_s1;

	// channel and seeding for the incoming sample
	always_comb begin
		raw_in  = s_axis_tdata[SAMPLE_WIDTH-1:0] & mask;
		seed_in = s_axis_tuser || seeding_frame_q;
		ch_in   = s_axis_tuser ? '0 : channel_index_q;
		ch_inc  = {1'b0, ch_in} + (AW+1)'(1);
		if (channel_count_q == '0) begin
			cnt_eff = CNT_CMP_W'(1);
		end else if (CNT_CMP_W'(channel_count_q) > CNT_CMP_W'(MAX_CHANNELS)) begin
			cnt_eff = CNT_CMP_W'(MAX_CHANNELS);
		end else begin
			cnt_eff = CNT_CMP_W'(channel_count_q);
		end
		wrap = CNT_CMP_W'(ch_inc) >= cnt_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_index_q <= '0;
			seeding_frame_q <= 1'b1;
		end else if (accept) begin
			channel_index_q <= wrap ? '0 : ch_inc[AW-1:0];
			seeding_frame_q <= seed_in && !wrap;
		end
	end

	dsf_ram #(
		.WIDTH (SAMPLE_WIDTH),
		.DEPTH (MAX_CHANNELS)
	) u_hist (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (ch_in),
		.wr_data (raw_in),
		.rd_en   (accept),
		.rd_addr (ch_in),
		.rd_data (prev_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= accept;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (out_en) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_comb begin
		x_val = to_val(raw_s1, mask, sign_bit, span, fmt_sgn);
		p_val = to_val(prev_rd, mask, sign_bit, span, fmt_sgn);
	end

	always_comb begin
		sum_full = (SW'(x_s3) <<< GAIN_FRAC_BITS) + SW'(prod_s3);
		sum_adj  = sum_full + (sum_full[SW-1] ? signed'(ROUND_ADD) : signed'(SW'(0)));
		res      = sum_adj >>> GAIN_FRAC_BITS;
		clip_c   = 1'b0;
		res_sat  = res;
		if (res > hi_v) begin
			res_sat = hi_v;
			clip_c  = 1'b1;
		end
		if (res < lo_v) begin
			res_sat = lo_v;
			clip_c  = 1'b1;
		end
		res_bits = res_sat[SAMPLE_WIDTH-1:0] & mask;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1  <= raw_in;
			seed_s1 <= seed_in;
		end
		if (en_s2 && valid_s1) begin
			raw_s2  <= raw_s1;
			seed_s2 <= seed_s1;
			x_s2    <= x_val;
			diff_s2 <= DFW'(x_val) - DFW'(p_val);
		end
		if (en_s3 && valid_s2) begin
			raw_s3  <= raw_s2;
			seed_s3 <= seed_s2;
			x_s3    <= x_s2;
			prod_s3 <= PW'(gain_q) * PW'(diff_s2);
		end
		if (out_en && valid_s3) begin
			sample_out_q <= DATA_W'(seed_s3 ? raw_s3 : res_bits);
			clipped_q    <= !seed_s3 && clip_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = sample_out_q;
	assign m_axis_tuser  = clipped_q;

endmodule

FILE: design/dsf_checker.sv
// ----------------------------------------------------------------------------
// dsf_checker
// port-level checks of the difference sharpening filter, bound to the top
// ----------------------------------------------------------------------------
`include "difference_sharpening_filter_unit_macros.svh"

module dsf_checker
	import dsf_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [DATA_W-1:0]    m_axis_tdata,  // [31:0] sample_out
	input logic                 m_axis_tuser,  // [0] clipped
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [GAIN_W-1:0]    cfg_data
);

	logic       in_xact;
	logic       out_xact;
	logic [2:0] inflight_q;
	logic [FMT_W-1:0] fmt_q;
	logic       fmt_narrow;

	assign in_xact    = s_axis_tvalid && s_axis_tready;
	assign out_xact   = m_axis_tvalid && m_axis_tready;
	assign fmt_narrow = (fmt_q == FMT_S8) || (fmt_q == FMT_U8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			fmt_q      <= FORMAT_RESET;
		end else begin
			inflight_q <= inflight_q + 3'(in_xact) - 3'(out_xact);
			if (cfg_valid && cfg_ready && (cfg_index == CFG_FORMAT)) begin
				fmt_q <= cfg_data[FMT_W-1:0];
			end
		end
	end

	`DSF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"stalled output transaction changed")

	`DSF_ASSERT_IMPLY(a_no_phantom, m_axis_tvalid, inflight_q != 3'd0,
		"output transaction without a sample in flight")

	`DSF_ASSERT_IMPLY(a_depth, 1'b1, inflight_q <= 3'd4,
		"more samples in flight than pipeline stages")

	`DSF_ASSERT_IMPLY(a_narrow_bits, m_axis_tvalid && fmt_narrow,
		m_axis_tdata[DATA_W-1:8] == '0,
		"8-bit format result has high bits set")

endmodule

bind difference_sharpening_filter_unit dsf_checker u_dsf_checker (.*);
